### rtl/core/priority_ready_queue_assert.svh
// assertion macros shared by the priority ready queue modules
`ifndef PRIORITY_READY_QUEUE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_ASSERT_SVH

// same-cycle implication under active-low reset
`define PRQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("priority_ready_queue assertion failed");

// next-cycle implication under active-low reset
`define PRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("priority_ready_queue assertion failed");

`endif

### rtl/core/prq_pkg.sv
// shared types and constants of the priority ready queue
package prq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 32;
	localparam int unsigned OCC_W = 6;

	typedef enum logic [1:0] {
		MODE_ENQ   = 2'd0,
		MODE_PICK  = 2'd1,
		MODE_STEAL = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_IDLE_IGN = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] task_id;
		logic [7:0] task_prio;
		logic       front_flag;
		logic       was_preempted;
		logic       is_idle;
		logic [7:0] running_prio;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [7:0]       out_task;
		logic [7:0]       out_prio;
		logic             resched;
		logic             mark_running_front;
		logic [OCC_W-1:0] occupancy;
	} out_beat_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stat_t;

endpackage

### rtl/core/prq_if.sv
// valid/ready channel interfaces for request and response beats
interface prq_in_if;
	logic             valid;
	logic             ready;
	prq_pkg::in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface prq_out_if;
	logic               valid;
	logic               ready;
	prq_pkg::out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/prq_ctrl.sv
// control state machine: accept, execute, hold response
module prq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  prq_pkg::stat_t stat,
	output prq_pkg::cmd_t  cmd
);

	prq_pkg::state_t state_q;
	prq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prq_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = prq_pkg::S_EXEC;
				end
			end
			prq_pkg::S_EXEC: begin
				state_d = prq_pkg::S_RESP;
			end
			prq_pkg::S_RESP: begin
				if (out_ready) begin
					state_d = prq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = prq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			prq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			prq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			prq_pkg::S_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	`include "priority_ready_queue_assert.svh"

	`PRQ_ASSERT_NEXT(a_load_then_exec, clk, arst_n, cmd.load, cmd.exec && !in_ready)
	`PRQ_ASSERT_NEXT(a_exec_then_resp, clk, arst_n, cmd.exec, out_valid && !in_ready)
	`PRQ_ASSERT_NOW(a_status_excl, clk, arst_n, 1'b1, !(stat.empty && stat.full))

endmodule

### rtl/core/prq_datapath.sv
// sorted shift-register queue cells, request latch and response register
module prq_datapath #(
	parameter int unsigned QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  prq_pkg::cmd_t       cmd,
	output prq_pkg::stat_t      stat,
	input  prq_pkg::in_beat_t   req_data,
	output prq_pkg::out_beat_t  rsp_data
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

	logic [7:0]          cell_task_q [QUEUE_DEPTH];
	logic [7:0]          cell_prio_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic                preempt_en_q;
	prq_pkg::in_beat_t   in_q;
	prq_pkg::out_beat_t  out_q;
	prq_pkg::out_beat_t  out_d;

	logic [QUEUE_DEPTH-1:0] after_v;
	logic                   enq_ok;
	logic                   pick_ok;
	logic                   steal_ok;
	logic [IDX_W-1:0]       tail_idx;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));

	assign enq_ok   = (in_q.mode == prq_pkg::MODE_ENQ) && !in_q.is_idle && !stat.full;
	assign pick_ok  = (in_q.mode == prq_pkg::MODE_PICK) && !stat.empty;
	assign steal_ok = (in_q.mode == prq_pkg::MODE_STEAL) && !stat.empty;
	assign tail_idx = IDX_W'(count_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preempt_en_q <= 1'b1;
		end else if (cfg_wr_en) begin
			preempt_en_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= req_data;
		end
		if (cmd.exec) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [7:0] ins_task;
		logic [7:0] ins_prio;
		logic [7:0] up_task;
		logic [7:0] up_prio;

		// new beat goes after this entry
		assign after_v[i] = (CNT_W'(i) < count_q) &&
			(in_q.front_flag ? (cell_prio_q[i] < in_q.task_prio)
			                 : (cell_prio_q[i] <= in_q.task_prio));

		if (i == 0) begin : g_head
			assign ins_task = in_q.task_id;
			assign ins_prio = in_q.task_prio;
		end else begin : g_body
			assign ins_task = after_v[i-1] ? in_q.task_id : cell_task_q[i-1];
			assign ins_prio = after_v[i-1] ? in_q.task_prio : cell_prio_q[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign up_task = cell_task_q[i];
			assign up_prio = cell_prio_q[i];
		end else begin : g_mid
			assign up_task = cell_task_q[i+1];
			assign up_prio = cell_prio_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (enq_ok && !after_v[i]) begin
					cell_task_q[i] <= ins_task;
					cell_prio_q[i] <= ins_prio;
				end else if (pick_ok) begin
					cell_task_q[i] <= up_task;
					cell_prio_q[i] <= up_prio;
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		out_d   = '0;
		priority if (in_q.mode == prq_pkg::MODE_ENQ) begin
			if (in_q.is_idle) begin
				out_d.status = prq_pkg::ST_IDLE_IGN;
			end else if (stat.full) begin
				out_d.status = prq_pkg::ST_FULL;
			end else begin
				count_d       = count_q + 1'b1;
				out_d.resched = !in_q.was_preempted && preempt_en_q &&
					(in_q.task_prio < in_q.running_prio);
			end
		end else if (in_q.mode == prq_pkg::MODE_PICK || in_q.mode == prq_pkg::MODE_STEAL) begin
			if (stat.empty) begin
				out_d.status = prq_pkg::ST_EMPTY;
			end else begin
				count_d = count_q - 1'b1;
				if (in_q.mode == prq_pkg::MODE_PICK) begin
					out_d.out_task = cell_task_q[0];
					out_d.out_prio = cell_prio_q[0];
				end else begin
					out_d.out_task = cell_task_q[tail_idx];
					out_d.out_prio = cell_prio_q[tail_idx];
				end
			end
		end else begin
			out_d.status = prq_pkg::ST_OK;
		end
		out_d.mark_running_front = out_d.resched;
		out_d.occupancy          = prq_pkg::OCC_W'(count_d);
	end

	assign rsp_data = out_q;

	`include "priority_ready_queue_assert.svh"

	`PRQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
	`PRQ_ASSERT_NEXT(a_enq_grows, clk, arst_n, cmd.exec && enq_ok, count_q == CNT_W'($past(count_q) + 1'b1))
	`PRQ_ASSERT_NEXT(a_remove_shrinks, clk, arst_n, cmd.exec && (pick_ok || steal_ok), count_q == CNT_W'($past(count_q) - 1'b1))
	`PRQ_ASSERT_NOW(a_head_sorted, clk, arst_n, count_q >= CNT_W'(2), cell_prio_q[0] <= cell_prio_q[1])

endmodule

### rtl/core/priority_ready_queue.sv
// top level of the priority ready queue
// Sorted ready queue of up to QUEUE_DEPTH tasks, head most urgent (lowest priority value).
// A request beat is latched, executed, then held as a response until the response channel
// takes it; the next request is taken once that beat has left. Enqueue, pick and steal finish
// in the execute step, every cell comparing and shifting in parallel. preempt_enable resets
// to 1; the user must keep it written only while the queue is idle, not enforced by the block.
module priority_ready_queue #(
	parameter int unsigned QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	prq_in_if.sink    req,
	prq_out_if.source rsp
);

	prq_pkg::cmd_t  cmd;
	prq_pkg::stat_t stat;

	prq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	prq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.stat        (stat),
		.req_data    (req.data),
		.rsp_data    (rsp.data)
	);

endmodule

### tb/priority_ready_queue_checker.sv
// checker for the priority ready queue: shadows the sorted queue, predicts and compares response beats
module priority_ready_queue_checker
	import prq_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	prq_in_if    req,
	prq_out_if   rsp,
	output int   fails,
	output int   pending,
	output int   checked,
	output int   resched_hits,
	output int   full_hits,
	output int   empty_hits
);

	logic [7:0] shadow_id [DEPTH];
	logic [7:0] shadow_prio [DEPTH];
	int unsigned shadow_count;
	logic preempt_en;
	out_beat_t due_rsp[$];

	function automatic int field_bad(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	task automatic apply_sched_op(input in_beat_t b, output out_beat_t r);
		int unsigned pos;
		int unsigned i;
		r = '0;
		case (mode_t'(b.mode))
			MODE_ENQ: begin
				if (b.is_idle) begin
					r.status = ST_IDLE_IGN;
				end else if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < shadow_count && (b.front_flag ? shadow_prio[pos] < b.task_prio
							: shadow_prio[pos] <= b.task_prio))
						pos++;
					for (i = shadow_count; i > pos; i--) begin
						shadow_id[i] = shadow_id[i-1];
						shadow_prio[i] = shadow_prio[i-1];
					end
					shadow_id[pos] = b.task_id;
					shadow_prio[pos] = b.task_prio;
					shadow_count++;
					if (!b.was_preempted && preempt_en && b.task_prio < b.running_prio) begin
						r.resched = 1'b1;
						r.mark_running_front = 1'b1;
					end
				end
			end
			MODE_PICK, MODE_STEAL: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else if (mode_t'(b.mode) == MODE_PICK) begin
					r.out_task = shadow_id[0];
					r.out_prio = shadow_prio[0];
					for (i = 0; i + 1 < shadow_count; i++) begin
						shadow_id[i] = shadow_id[i+1];
						shadow_prio[i] = shadow_prio[i+1];
					end
					shadow_count--;
				end else begin
					r.out_task = shadow_id[shadow_count-1];
					r.out_prio = shadow_prio[shadow_count-1];
					shadow_count--;
				end
			end
			default: begin
			end
		endcase
		r.occupancy = shadow_count[OCC_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_beat_t exp_b;
		out_beat_t act_b;
		if (!arst_n) begin
			shadow_count = 0;
			preempt_en = 1'b1;
			due_rsp.delete();
			fails = 0;
			pending = 0;
			checked = 0;
			resched_hits = 0;
			full_hits = 0;
			empty_hits = 0;
		end else begin
			if (cfg_wr_en)
				preempt_en = cfg_wr_data;
			if (req.valid && req.ready) begin
				apply_sched_op(req.data, exp_b);
				due_rsp.push_back(exp_b);
			end
			if (rsp.valid && rsp.ready) begin
				act_b = rsp.data;
				if (due_rsp.size() == 0) begin
					$error("response beat with nothing outstanding");
					fails++;
				end else begin
					exp_b = due_rsp.pop_front();
					fails += field_bad("status", exp_b.status, act_b.status);
					fails += field_bad("out_task", exp_b.out_task, act_b.out_task);
					fails += field_bad("out_prio", exp_b.out_prio, act_b.out_prio);
					fails += field_bad("resched", exp_b.resched, act_b.resched);
					fails += field_bad("mark_running_front", exp_b.mark_running_front,
						act_b.mark_running_front);
					fails += field_bad("occupancy", exp_b.occupancy, act_b.occupancy);
					checked++;
					resched_hits += exp_b.resched;
					if (exp_b.status == ST_FULL)
						full_hits++;
					if (exp_b.status == ST_EMPTY)
						empty_hits++;
				end
			end
			pending = due_rsp.size();
		end
	end

endmodule

### tb/priority_ready_queue_tb.sv
// testbench top for the priority ready queue: stimulus, idle/stall phases and verdict
module priority_ready_queue_tb;
	import prq_pkg::*;

	localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PER_PHASE = 275;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;
	int fails, pending, checked, resched_hits, full_hits, empty_hits;
	int send_idle_pct;
	int recv_stall_pct;
	int sent;
	int cycles = 0;

	prq_in_if req_ch ();
	prq_out_if rsp_ch ();

	priority_ready_queue #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	priority_ready_queue_checker #(.DEPTH(DEPTH)) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.fails        (fails),
		.pending      (pending),
		.checked      (checked),
		.resched_hits (resched_hits),
		.full_hits    (full_hits),
		.empty_hits   (empty_hits)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("priority_ready_queue: mismatch");
			$finish;
		end
	end

	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic in_beat_t make_beat(mode_t m, int id, int prio, bit front, bit preempted,
			bit idle, int run_prio);
		in_beat_t b;
		b.mode = m;
		b.task_id = id[7:0];
		b.task_prio = prio[7:0];
		b.front_flag = front;
		b.was_preempted = preempted;
		b.is_idle = idle;
		b.running_prio = run_prio[7:0];
		return b;
	endfunction

	// narrow priority range half the time so equal priorities pile up
	function automatic in_beat_t rand_beat(int enq_pct);
		in_beat_t b;
		int roll;
		b.task_id = 8'($urandom);
		b.task_prio = 8'($urandom_range(1) ? $urandom_range(0, 7) : $urandom_range(0, 255));
		b.running_prio = 8'($urandom_range(1) ? $urandom_range(0, 8) : $urandom_range(0, 255));
		b.front_flag = 1'($urandom_range(1));
		b.was_preempted = 1'($urandom_range(1));
		b.is_idle = ($urandom_range(99) < 8);
		roll = $urandom_range(99);
		if (roll < 3)
			b.mode = MODE_NOP;
		else if (roll < 3 + enq_pct * 97 / 100)
			b.mode = MODE_ENQ;
		else
			b.mode = $urandom_range(1) ? MODE_PICK : MODE_STEAL;
		return b;
	endfunction

	task automatic send_req(input in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= b;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
		sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_preempt(input bit v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_directed();
		send_req(make_beat(MODE_PICK, 0, 0, 0, 0, 0, 0));
		send_req(make_beat(MODE_STEAL, 0, 0, 0, 0, 0, 0));
		send_req(make_beat(MODE_NOP, 255, 255, 1, 1, 1, 255));
		send_req(make_beat(MODE_ENQ, 9, 0, 0, 0, 1, 255));
		send_req(make_beat(MODE_ENQ, 255, 255, 1, 0, 0, 255));
		send_req(make_beat(MODE_ENQ, 0, 0, 0, 0, 0, 255));
		send_req(make_beat(MODE_ENQ, 8'h11, 0, 0, 1, 0, 1));
		send_req(make_beat(MODE_ENQ, 1, 5, 0, 0, 0, 0));
		send_req(make_beat(MODE_ENQ, 2, 5, 0, 0, 0, 0));
		send_req(make_beat(MODE_ENQ, 3, 5, 1, 0, 0, 0));
		send_req(make_beat(MODE_ENQ, 4, 5, 1, 0, 0, 0));
		send_req(make_beat(MODE_ENQ, 7, 7, 0, 0, 0, 7));
		send_req(make_beat(MODE_NOP, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 9; i++)
			send_req(make_beat(i % 3 == 2 ? MODE_STEAL : MODE_PICK, 0, 0, 0, 0, 0, 0));
	endtask

	// fill past full, drain past empty, then mixed groups with a varying enqueue bias
	task automatic run_random();
		in_beat_t b;
		int left;
		int enq_pct;
		for (int i = 0; i < DEPTH + 4; i++) begin
			b = rand_beat(100);
			b.mode = MODE_ENQ;
			b.is_idle = 1'b0;
			send_req(b);
		end
		for (int i = 0; i < DEPTH + 8; i++) begin
			b = rand_beat(0);
			b.mode = $urandom_range(1) ? MODE_PICK : MODE_STEAL;
			send_req(b);
		end
		left = RAND_PER_PHASE - 2 * DEPTH - 12;
		while (left > 0) begin
			case ($urandom_range(2))
				0: enq_pct = 85;
				1: enq_pct = 50;
				default: enq_pct = 20;
			endcase
			for (int i = 0; i < 40 && left > 0; i++) begin
				send_req(rand_beat(enq_pct));
				left--;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sent = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 86; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 86; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			settle();
			write_preempt(phase % 2 == 0);
			if (phase == 0)
				run_directed();
			run_random();
		end
		settle();
		$display("sent %0d requests over four idle/stall phases, preemption on and off", sent);
		$display("checked %0d responses: %0d reschedules, %0d overflow drops, %0d empty removes",
			checked, resched_hits, full_hits, empty_hits);
		if (fails == 0)
			$display("priority_ready_queue: match");
		else
			$display("priority_ready_queue: mismatch");
		$finish;
	end

endmodule
